FILE: src/w2l_pkg.sv
// Shared types, constants and tables for the world-to-local pose transform.
package w2l_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN      = 24;

	// Datapath widths.
	localparam int CW      = 34;                // CORDIC x, y and z
	localparam int NUM_W   = 40;                // signed dividend ahead of the fraction shift
	localparam int QUO_W   = 32;                // quotient bits produced by the divider
	localparam int DIV_LAT = QUO_W + 2;         // prep stage, one stage per bit, clamp stage

	localparam int QUEUE_DEPTH = 4;

	localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
	localparam logic [63:0] PHASE_K        = INV_TWO_PI_Q64 >> FRAC_BITS;
	localparam logic [27:0] PHASE_K_LO     = PHASE_K[27:0];
	localparam logic [27:0] PHASE_K_HI     = PHASE_K[55:28];

	localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 34'sh026DD3B6A;

	localparam logic [1:0] MODE_COMPUTED = 2'd0;
	localparam logic [1:0] MODE_KEEP     = 2'd1;
	localparam logic [1:0] MODE_WORLD    = 2'd2;

	// One classified pose as it leaves the front end.
	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] rot;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] csx;
		logic signed [31:0] csy;
		logic signed [31:0] psx;
		logic signed [31:0] psy;
		logic signed [30:0] prot;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
	} side_t;

	// CORDIC angle table in turns scaled by 2^32.
	function automatic logic signed [CW-1:0] atan_turns(input int unsigned idx);
		logic signed [CW-1:0] v;
		case (idx)
			0:  v = 34'sd536870912;
			1:  v = 34'sd316933406;
			2:  v = 34'sd167458907;
			3:  v = 34'sd85004756;
			4:  v = 34'sd42667331;
			5:  v = 34'sd21354465;
			6:  v = 34'sd10679838;
			7:  v = 34'sd5340245;
			8:  v = 34'sd2670163;
			9:  v = 34'sd1335087;
			10: v = 34'sd667544;
			11: v = 34'sd333772;
			12: v = 34'sd166886;
			13: v = 34'sd83443;
			14: v = 34'sd41722;
			15: v = 34'sd20861;
			16: v = 34'sd10430;
			17: v = 34'sd5215;
			18: v = 34'sd2608;
			19: v = 34'sd1304;
			20: v = 34'sd652;
			21: v = 34'sd326;
			22: v = 34'sd163;
			23: v = 34'sd81;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage

FILE: src/w2l_queue.sv
// Short queue of classified poses between the front end and the compute pipeline.
module w2l_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  w2l_pkg::side_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output w2l_pkg::side_t  pop_data
);

	localparam int DEPTH = w2l_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	w2l_pkg::side_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == (PTR_W+1)'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(DEPTH))
		else $error("queue count exceeds its depth");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on a lone push");

endmodule

FILE: src/w2l_front.sv
// Front end: input transfers, the epsilon register and classification of each pose.
module w2l_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wen,
	input  logic [16:0]     cfg_wdata,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [319:0]    s_tdata,
	input  logic [1:0]      s_tuser,
	input  logic            q_full,
	output logic            q_push,
	output w2l_pkg::side_t  q_data
);

	logic [16:0]        eps_q;
	logic signed [31:0] cx, cy, csx, csy, px, py, psx, psy;
	logic signed [30:0] cr, pr;
	logic               cvalid, pvalid;
	logic [32:0]        mag_x, mag_y;
	logic               scale_tiny;
	logic [1:0]         mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 17'd1;
		end else if (cfg_wen) begin
			eps_q <= cfg_wdata;
		end
	end

	assign cx     = s_tdata[31:0];
	assign cy     = s_tdata[63:32];
	assign cr     = s_tdata[94:64];
	assign csx    = s_tdata[126:95];
	assign csy    = s_tdata[158:127];
	assign px     = s_tdata[190:159];
	assign py     = s_tdata[222:191];
	assign pr     = s_tdata[253:223];
	assign psx    = s_tdata[285:254];
	assign psy    = s_tdata[317:286];
	assign cvalid = s_tuser[0];
	assign pvalid = s_tuser[1];

	assign mag_x = psx[31] ? (33'd0 - {psx[31], psx}) : {1'b0, psx};
	assign mag_y = psy[31] ? (33'd0 - {psy[31], psy}) : {1'b0, psy};

	// A zero scale is rejected even when epsilon is zero, so no computed result divides by it.
	assign scale_tiny = (psx == 32'sd0) || (psy == 32'sd0) ||
		(mag_x < {16'd0, eps_q}) || (mag_y < {16'd0, eps_q});

	always_comb begin
		if (!cvalid) begin
			mode = w2l_pkg::MODE_KEEP;
		end else if (!pvalid) begin
			mode = w2l_pkg::MODE_WORLD;
		end else if (scale_tiny) begin
			mode = w2l_pkg::MODE_KEEP;
		end else begin
			mode = w2l_pkg::MODE_COMPUTED;
		end
	end

	always_comb begin
		q_data.mode = mode;
		if (mode == w2l_pkg::MODE_WORLD) begin
			q_data.rot = {cr[30], cr};
		end else begin
			q_data.rot = {cr[30], cr} - {pr[30], pr};
		end
		q_data.cx   = cx;
		q_data.cy   = cy;
		q_data.csx  = csx;
		q_data.csy  = csy;
		q_data.psx  = psx;
		q_data.psy  = psy;
		q_data.prot = pr;
		q_data.dx   = {cx[31], cx} - {px[31], px};
		q_data.dy   = {cy[31], cy} - {py[31], py};
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

endmodule

FILE: src/w2l_cordic.sv
// Unrolled rotation-mode CORDIC, one register stage per iteration.
module w2l_cordic #(
	parameter int STAGES = w2l_pkg::CORDIC_STAGES
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [29:0]                      z_in,
	input  logic [1:0]                       quad_in,
	output logic signed [w2l_pkg::CW-1:0]    x_out,
	output logic signed [w2l_pkg::CW-1:0]    y_out,
	output logic [1:0]                       quad_out
);

	localparam int W = w2l_pkg::CW;

	logic signed [W-1:0] x_sn [STAGES];
	logic signed [W-1:0] y_sn [STAGES];
	logic signed [W-1:0] z_sn [STAGES];
	logic [1:0]          quad_sn [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [W-1:0] xi, yi, zi;
		logic [1:0]          qi;

		if (i == 0) begin : g_first
			assign xi = w2l_pkg::CORDIC_INV_GAIN;
			assign yi = '0;
			assign zi = {4'd0, z_in};
			assign qi = quad_in;
		end else begin : g_next
			assign xi = x_sn[i-1];
			assign yi = y_sn[i-1];
			assign zi = z_sn[i-1];
			assign qi = quad_sn[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					x_sn[i] <= xi - (yi >>> i);
					y_sn[i] <= yi + (xi >>> i);
					z_sn[i] <= zi - w2l_pkg::atan_turns(i);
				end else begin
					x_sn[i] <= xi + (yi >>> i);
					y_sn[i] <= yi - (xi >>> i);
					z_sn[i] <= zi + w2l_pkg::atan_turns(i);
				end
				quad_sn[i] <= qi;
			end
		end
	end

	assign x_out    = x_sn[STAGES-1];
	assign y_out    = y_sn[STAGES-1];
	assign quad_out = quad_sn[STAGES-1];

endmodule

FILE: src/w2l_div.sv
// Pipelined restoring divider for Q16.16 quotients with clamping to 32 bits.
module w2l_div (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [w2l_pkg::NUM_W-1:0]   num,
	input  logic signed [31:0]                 den,
	output logic signed [31:0]                 quo,
	output logic                               sat
);

	localparam int NW = w2l_pkg::NUM_W + w2l_pkg::FRAC_BITS;
	localparam int QW = w2l_pkg::QUO_W;

	logic [w2l_pkg::NUM_W-1:0] nmag_c;
	logic [NW-1:0]             n_c;
	logic [31:0]               dmag_c;

	logic [31:0]    rem_sn [QW+1];
	logic [QW-1:0]  low_sn [QW+1];
	logic [QW-1:0]  quo_sn [QW+1];
	logic [31:0]    d_sn   [QW+1];
	logic [QW:0]    neg_sn;
	logic [QW:0]    ovf_sn;

	logic [QW-1:0]  qf;
	logic           neg_f;
	logic           sat_c;
	logic [31:0]    val_c;

	assign nmag_c = num[w2l_pkg::NUM_W-1] ? w2l_pkg::NUM_W'(-num) : w2l_pkg::NUM_W'(num);
	assign n_c    = {nmag_c, {w2l_pkg::FRAC_BITS{1'b0}}};
	assign dmag_c = den[31] ? (32'd0 - 32'(den)) : 32'(den);

	// A quotient of 2^32 or more shows up in the top bits alone; the bit stages handle the rest.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_sn[0] <= 32'(n_c[NW-1:QW]);
			low_sn[0] <= n_c[QW-1:0];
			quo_sn[0] <= '0;
			d_sn[0]   <= dmag_c;
			neg_sn[0] <= num[w2l_pkg::NUM_W-1] ^ den[31];
			ovf_sn[0] <= (32'(n_c[NW-1:QW]) >= dmag_c);
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_bit
		logic [32:0] r2;
		logic        ge;

		assign r2 = {rem_sn[i], low_sn[i][QW-1]};
		assign ge = (r2 >= {1'b0, d_sn[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sn[i+1] <= ge ? 32'(r2 - {1'b0, d_sn[i]}) : r2[31:0];
				low_sn[i+1] <= {low_sn[i][QW-2:0], 1'b0};
				quo_sn[i+1] <= {quo_sn[i][QW-2:0], ge};
				d_sn[i+1]   <= d_sn[i];
				neg_sn[i+1] <= neg_sn[i];
				ovf_sn[i+1] <= ovf_sn[i];
			end
		end
	end

	assign qf    = quo_sn[QW];
	assign neg_f = neg_sn[QW];

	always_comb begin
		if (ovf_sn[QW]) begin
			sat_c = 1'b1;
		end else if (neg_f) begin
			sat_c = (qf > 32'h8000_0000);
		end else begin
			sat_c = qf[31];
		end
		if (sat_c) begin
			val_c = neg_f ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			val_c = neg_f ? (32'd0 - qf) : qf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= val_c;
			sat <= sat_c;
		end
	end

endmodule

FILE: src/w2l_back.sv
// Back end: phase reduction, CORDIC, offset rotation, four dividers and the output register.
module w2l_back #(
	parameter int CORDIC_STAGES = w2l_pkg::CORDIC_STAGES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  w2l_pkg::side_t  q_data,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [159:0]    m_tdata,
	output logic [2:0]      m_tuser
);

	localparam int CS = CORDIC_STAGES;
	localparam int DL = w2l_pkg::DIV_LAT;
	localparam int W  = w2l_pkg::CW;
	localparam int NW = w2l_pkg::NUM_W;

	logic adv;

	logic                 v_s1;
	w2l_pkg::side_t       side_s1;
	logic signed [59:0]   pa_s1, pb_s1;

	logic                 v_s2;
	w2l_pkg::side_t       side_s2;
	logic [31:0]          ph_s2;
	logic [63:0]          phase_c;

	logic signed [W-1:0]  cx_out, cy_out;
	logic [1:0]           cquad;
	logic [CS-1:0]        vc_sn;
	w2l_pkg::side_t       sc_sn [CS];

	logic signed [W-1:0]  xs_c, ys_c, cs_c, sn_c;
	logic                 v_s3;
	w2l_pkg::side_t       side_s3;
	logic signed [31:0]   cs_s3, sn_s3;

	logic                 v_s4;
	w2l_pkg::side_t       side_s4;
	logic signed [64:0]   pxc_s4, pys_s4, pxs_s4, pyc_s4;

	logic signed [66:0]   tx_c, ty_c;
	logic                 v_s5;
	w2l_pkg::side_t       side_s5;
	logic signed [NW-1:0] rx_s5, ry_s5;

	logic signed [31:0]   qx, qy, qsx, qsy;
	logic                 satx, saty, satsx, satsy;
	logic [DL-1:0]        vd_sn;
	w2l_pkg::side_t       sd_sn [DL];

	logic                 v_o;
	logic signed [31:0]   ox_q, oy_q, orot_q, osx_q, osy_q;
	logic [1:0]           omode_q;
	logic                 osat_q;
	w2l_pkg::side_t       sf;

	// The whole pipeline moves together and holds while a result waits.
	assign adv   = !v_o || m_tready;
	assign q_pop = adv && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			vc_sn <= '0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			vd_sn <= '0;
			v_o   <= 1'b0;
		end else if (adv) begin
			v_s1  <= q_valid;
			v_s2  <= v_s1;
			vc_sn <= {vc_sn[CS-2:0], v_s2};
			v_s3  <= vc_sn[CS-1];
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			vd_sn <= {vd_sn[DL-2:0], v_s5};
			v_o   <= vd_sn[DL-1];
		end
	end

	// Angle times 2^64/(2 pi), split into two partial products.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= q_data;
			pa_s1   <= q_data.prot * $signed({1'b0, w2l_pkg::PHASE_K_LO});
			pb_s1   <= q_data.prot * $signed({1'b0, w2l_pkg::PHASE_K_HI});
		end
	end

	assign phase_c = 64'd0 - (64'(pa_s1) + (64'(pb_s1) << 28));

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			ph_s2   <= phase_c[63:32];
		end
	end

	w2l_cordic #(
		.STAGES (CS)
	) u_cordic (
		.clk      (clk),
		.en       (adv),
		.z_in     (ph_s2[29:0]),
		.quad_in  (ph_s2[31:30]),
		.x_out    (cx_out),
		.y_out    (cy_out),
		.quad_out (cquad)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_sn[0] <= side_s2;
			for (int i = 1; i < CS; i++) begin
				sc_sn[i] <= sc_sn[i-1];
			end
		end
	end

	assign xs_c = cx_out >>> 2;
	assign ys_c = cy_out >>> 2;

	always_comb begin
		case (cquad)
			2'd0: begin
				cs_c = xs_c;
				sn_c = ys_c;
			end
			2'd1: begin
				cs_c = -ys_c;
				sn_c = xs_c;
			end
			2'd2: begin
				cs_c = -xs_c;
				sn_c = -ys_c;
			end
			default: begin
				cs_c = ys_c;
				sn_c = -xs_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= sc_sn[CS-1];
			cs_s3   <= 32'(cs_c);
			sn_s3   <= 32'(sn_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_s3;
			pxc_s4  <= side_s3.dx * cs_s3;
			pys_s4  <= side_s3.dy * sn_s3;
			pxs_s4  <= side_s3.dx * sn_s3;
			pyc_s4  <= side_s3.dy * cs_s3;
		end
	end

	// Round half up from Q28 products back to the position's fraction.
	assign tx_c = 67'(pxc_s4) - 67'(pys_s4) + 67'sd134217728;
	assign ty_c = 67'(pxs_s4) + 67'(pyc_s4) + 67'sd134217728;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			rx_s5   <= NW'(tx_c >>> 28);
			ry_s5   <= NW'(ty_c >>> 28);
		end
	end

	w2l_div u_div_x (
		.clk (clk), .en (adv), .num (rx_s5), .den (side_s5.psx), .quo (qx), .sat (satx)
	);

	w2l_div u_div_y (
		.clk (clk), .en (adv), .num (ry_s5), .den (side_s5.psy), .quo (qy), .sat (saty)
	);

	w2l_div u_div_sx (
		.clk (clk), .en (adv), .num (NW'(side_s5.csx)), .den (side_s5.psx),
		.quo (qsx), .sat (satsx)
	);

	w2l_div u_div_sy (
		.clk (clk), .en (adv), .num (NW'(side_s5.csy)), .den (side_s5.psy),
		.quo (qsy), .sat (satsy)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_sn[0] <= side_s5;
			for (int i = 1; i < DL; i++) begin
				sd_sn[i] <= sd_sn[i-1];
			end
		end
	end

	assign sf = sd_sn[DL-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			omode_q <= sf.mode;
			unique case (sf.mode)
				w2l_pkg::MODE_COMPUTED: begin
					ox_q   <= qx;
					oy_q   <= qy;
					orot_q <= sf.rot;
					osx_q  <= qsx;
					osy_q  <= qsy;
					osat_q <= satx | saty | satsx | satsy;
				end
				w2l_pkg::MODE_WORLD: begin
					ox_q   <= sf.cx;
					oy_q   <= sf.cy;
					orot_q <= sf.rot;
					osx_q  <= sf.csx;
					osy_q  <= sf.csy;
					osat_q <= 1'b0;
				end
				default: begin
					ox_q   <= '0;
					oy_q   <= '0;
					orot_q <= '0;
					osx_q  <= '0;
					osy_q  <= '0;
					osat_q <= 1'b0;
				end
			endcase
		end
	end

	assign m_tvalid = v_o;
	assign m_tdata  = {osy_q, osx_q, orot_q, oy_q, ox_q};
	assign m_tuser  = {osat_q, omode_q};

	a_keep_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_o && omode_q == w2l_pkg::MODE_KEEP) |->
			(ox_q == '0 && oy_q == '0 && orot_q == '0 && osx_q == '0 && osy_q == '0 && !osat_q))
		else $error("keep-local result carries nonzero fields");

	a_world_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		(v_o && omode_q == w2l_pkg::MODE_WORLD) |-> !osat_q)
		else $error("world-copy result flagged as saturated");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv) |=> ($stable(vd_sn) && $stable(omode_q) && v_o))
		else $error("pipeline moved while the output stalled");

endmodule

FILE: src/world_to_local_transform_2d.sv
// Top level of the world-to-local 2D pose transform.
//
//  channel  direction  handshake          payload
//  s_axis   in         s_tvalid/s_tready  s_tdata (10 pose fields), s_tuser (2 valid flags)
//  m_axis   out        m_tvalid/m_tready  m_tdata (5 local fields), m_tuser (mode, saturated)
//  cfg      in         cfg_wen            cfg_wdata = scale_epsilon
//
// One pose per cycle is accepted and one result per cycle is delivered while m_tready is high.
// From the queue head a pose passes through the phase registers, the CORDIC stages, the
// rotation registers, the divider's prep, quotient-bit and clamp stages and the output register
// to m_tvalid; the queue holds each pose in a register before it reaches the head.
// Reset is asynchronous and active low; it empties the queue and pipeline and sets epsilon to 1.
// A stalled output holds the whole pipeline; the four-entry queue keeps accepting until full.
module world_to_local_transform_2d #(
	parameter int CORDIC_STAGES = w2l_pkg::CORDIC_STAGES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [16:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// child_world_x, child_world_y, child_world_rot, child_world_scale_x, child_world_scale_y,
	// parent_world_x, parent_world_y, parent_world_rot, parent_world_scale_x,
	// parent_world_scale_y, zero fill
	input  logic [319:0] s_tdata,
	// child_world_valid, parent_valid
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// local_x, local_y, local_rot, local_scale_x, local_scale_y
	output logic [159:0] m_tdata,
	// result_mode (2 bits), saturated
	output logic [2:0]   m_tuser
);

	w2l_pkg::side_t push_data;
	w2l_pkg::side_t pop_data;
	logic           push, full, pop, pop_valid;

	w2l_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (full),
		.q_push    (push),
		.q_data    (push_data)
	);

	w2l_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	w2l_back #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (pop_valid),
		.q_data   (pop_data),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: sim/world_to_local_transform_2d_tb.sv
// Self-checking testbench for the world-to-local 2D pose transform.
module world_to_local_transform_2d_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = w2l_pkg::CORDIC_STAGES + 60;

	typedef struct {
		logic signed [31:0] cx, cy, csx, csy, px, py, psx, psy;
		logic signed [30:0] cr, pr;
		bit                 cv, pv;
	} pose_t;

	typedef struct {
		logic [31:0] x, y, rot, sx, sy;
		logic [1:0]  mode;
		bit          sat;
	} local_pose_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wen = 1'b0;
	logic [16:0]  cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [319:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [159:0] m_tdata;
	logic [2:0]   m_tuser;

	world_to_local_transform_2d dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	pose_t       pending_poses[$];
	local_pose_t expected_poses[$];
	pose_t       offered;
	logic [16:0] epsilon = 17'd1;
	int          cyc = 0, sent = 0, taken = 0, received = 0, errors = 0;
	int          hold_left = 0, n_sat = 0;
	int          mode_seen[3] = '{0, 0, 0};
	bit          hold_done = 1'b0;
	bit          running = 1'b0;
	string       field_names[5] = '{"local_x", "local_y", "local_rot", "local_scale_x",
		"local_scale_y"};

	// Between these cycles neither side idles at random.
	function automatic bit idle_now();
		if (cyc > 1500 && cyc < 2500)
			return 1'b0;
		return $urandom_range(99) < 14;
	endfunction

	function automatic logic [31:0] div_clamped(input longint n, input longint d,
			inout bit sat);
		longint q;
		q = (n * 65536) / d;
		if (q > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'h7FFFFFFF;
		end
		if (q < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return q[31:0];
	endfunction

	function automatic local_pose_t solve_local(pose_t p, logic [16:0] eps);
		longint atan_q32[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861};
		local_pose_t r;
		longint rot, x, y, z, xs, ys, cs, sn, dx, dy, rx, ry, asx, asy;
		logic [63:0] phase;
		logic [31:0] p32;
		bit sat;
		r = '{default: '0};
		sat = 1'b0;
		asx = p.psx < 0 ? -longint'(p.psx) : longint'(p.psx);
		asy = p.psy < 0 ? -longint'(p.psy) : longint'(p.psy);
		if (!p.cv) begin
			r.mode = w2l_pkg::MODE_KEEP;
		end else if (!p.pv) begin
			r.mode = w2l_pkg::MODE_WORLD;
			r.x = p.cx;
			r.y = p.cy;
			r.rot = 32'(signed'(p.cr));
			r.sx = p.csx;
			r.sy = p.csy;
		end else if (p.psx == 0 || p.psy == 0 || asx < eps || asy < eps) begin
			r.mode = w2l_pkg::MODE_KEEP;
		end else begin
			r.mode = w2l_pkg::MODE_COMPUTED;
			rot = p.pr;
			phase = 64'd0 - (64'(rot) * w2l_pkg::PHASE_K);
			p32 = phase[63:32];
			z = longint'(p32[29:0]);
			x = longint'(w2l_pkg::CORDIC_INV_GAIN);
			y = 0;
			for (int i = 0; i < w2l_pkg::CORDIC_STAGES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= atan_q32[i];
				end else begin
					x += ys; y -= xs; z += atan_q32[i];
				end
			end
			x = x >>> 2;
			y = y >>> 2;
			case (p32[31:30])
				2'd0: begin cs = x;  sn = y;  end
				2'd1: begin cs = -y; sn = x;  end
				2'd2: begin cs = -x; sn = -y; end
				default: begin cs = y; sn = -x; end
			endcase
			dx = longint'(p.cx) - longint'(p.px);
			dy = longint'(p.cy) - longint'(p.py);
			rx = (dx * cs - dy * sn + (64'sd1 <<< 27)) >>> 28;
			ry = (dx * sn + dy * cs + (64'sd1 <<< 27)) >>> 28;
			r.x = div_clamped(rx, p.psx, sat);
			r.y = div_clamped(ry, p.psy, sat);
			r.rot = 32'(longint'(p.cr) - longint'(p.pr));
			r.sx = div_clamped(p.csx, p.psx, sat);
			r.sy = div_clamped(p.csy, p.psy, sat);
		end
		r.sat = sat;
		return r;
	endfunction

	// Driver: a new pose goes out once the previous transfer has completed.
	always @(posedge clk) begin
		if (running) begin
			if (s_tvalid && s_tready) begin
				expected_poses.push_back(solve_local(offered, epsilon));
				taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_poses.size() > 0 && !idle_now()) begin
					offered = pending_poses.pop_front();
					s_tdata <= {2'b00, offered.psy, offered.psx, offered.pr, offered.py,
						offered.px, offered.csy, offered.csx, offered.cr, offered.cy,
						offered.cx};
					s_tuser <= {offered.pv, offered.cv};
					s_tvalid <= 1'b1;
					sent++;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each transfer and holds off once for a long stretch.
	always @(posedge clk) begin
		local_pose_t e;
		logic [31:0] got[5];
		logic [31:0] want[5];
		if (m_tvalid && m_tready) begin
			received++;
			if (expected_poses.size() == 0) begin
				$error("result with no pose outstanding");
				errors++;
			end else begin
				e = expected_poses.pop_front();
				want = '{e.x, e.y, e.rot, e.sx, e.sy};
				for (int i = 0; i < 5; i++) begin
					got[i] = m_tdata[32*i +: 32];
					if (got[i] !== want[i]) begin
						$error("%s: expected %0d, got %0d", field_names[i],
							$signed(want[i]), $signed(got[i]));
						errors++;
					end
				end
				if (m_tuser[1:0] !== e.mode) begin
					$error("result_mode: expected %0d, got %0d", e.mode, m_tuser[1:0]);
					errors++;
				end
				if (m_tuser[2] !== e.sat) begin
					$error("saturated: expected %0d, got %0d", e.sat, m_tuser[2]);
					errors++;
				end
				if (e.mode <= 2)
					mode_seen[e.mode]++;
				n_sat += e.sat;
			end
		end
		if (!hold_done && taken >= 700) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && !idle_now();
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("cycle limit reached, %0d poses still outstanding",
				expected_poses.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000000)) - 1000000);
			2: return 32'h7FFFFFFF;
			3: return 32'h80000000;
			default: return 32'($signed($urandom_range(400)) - 200) <<< 16;
		endcase
	endfunction

	function automatic logic [31:0] pick_scale(logic [16:0] eps);
		logic [31:0] v;
		case ($urandom_range(7))
			0: v = $urandom;
			1: v = 32'($urandom_range(4));
			2: v = 32'(eps) + 32'($urandom_range(2)) - 32'd1;
			3: v = 32'($urandom_range(2048));
			default: v = 32'($urandom_range(4 * 65536, 65536 / 8));
		endcase
		return $urandom_range(1) ? -v : v;
	endfunction

	function automatic pose_t random_pose(logic [16:0] eps);
		pose_t p;
		p.cx = pick_coord(); p.cy = pick_coord();
		p.px = pick_coord(); p.py = pick_coord();
		p.cr = $urandom_range(3) == 0 ? 31'($urandom) : 31'($signed($urandom_range(823550))
			- 411775);
		p.pr = $urandom_range(3) == 0 ? 31'($urandom) : 31'($signed($urandom_range(823550))
			- 411775);
		p.csx = $urandom_range(3) == 0 ? $urandom : pick_scale(eps);
		p.csy = $urandom_range(3) == 0 ? $urandom : pick_scale(eps);
		p.psx = pick_scale(eps);
		p.psy = pick_scale(eps);
		p.cv = $urandom_range(15) != 0;
		p.pv = $urandom_range(11) != 0;
		return p;
	endfunction

	function automatic pose_t plain_pose();
		pose_t p;
		p = '{default: '0};
		p.psx = 32'h10000; p.psy = 32'h10000;
		p.csx = 32'h10000; p.csy = 32'h10000;
		p.cv = 1'b1; p.pv = 1'b1;
		return p;
	endfunction

	task automatic wait_idle();
		while (pending_poses.size() > 0 || s_tvalid || expected_poses.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_epsilon(logic [16:0] v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		epsilon = v;
		@(posedge clk);
	endtask

	initial begin
		pose_t p;
		logic [16:0] settings[5];
		settings = '{17'd0, 17'd131071, 17'd65536, 17'd300, 17'($urandom_range(131071))};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running = 1'b1;

		// Directed poses at the reset epsilon of one LSB.
		p = plain_pose(); pending_poses.push_back(p);
		p.cx = 32'h7FFFFFFF; p.cy = 32'h7FFFFFFF; p.px = 32'h80000000; p.py = 32'h80000000;
		p.cr = 31'h3FFFFFFF; p.pr = 31'h40000000; p.psx = 32'h1; p.psy = 32'hFFFFFFFF;
		pending_poses.push_back(p);
		p.cx = 32'h80000000; p.cy = 32'h80000000; p.px = 32'h7FFFFFFF; p.py = 32'h7FFFFFFF;
		p.cr = 31'h40000000; p.pr = 31'h3FFFFFFF; p.csx = 32'h7FFFFFFF;
		p.csy = 32'h80000000; p.psx = 32'h80000000; p.psy = 32'h7FFFFFFF;
		pending_poses.push_back(p);
		p = plain_pose(); p.csx = 32'h7FFFFFFF; p.csy = 32'h80000000;
		p.psx = 32'h1; p.psy = 32'h1; pending_poses.push_back(p);
		p = plain_pose(); p.cv = 1'b0; p.cx = 32'h1234; pending_poses.push_back(p);
		p = plain_pose(); p.cv = 1'b0; p.pv = 1'b0; pending_poses.push_back(p);
		p = plain_pose(); p.pv = 1'b0; p.cx = 32'h80000000; p.cy = 32'h7FFFFFFF;
		p.cr = 31'h40000000; p.csx = 32'hFFFFFFFF; pending_poses.push_back(p);
		p = plain_pose(); p.psx = 32'h0; pending_poses.push_back(p);
		p = plain_pose(); p.psy = 32'h0; pending_poses.push_back(p);
		for (int q = 0; q < 8; q++) begin
			p = plain_pose();
			p.cx = 32'h30000; p.cy = 32'h10000;
			p.pr = 31'(q * 51472);
			p.cr = -p.pr;
			pending_poses.push_back(p);
		end
		for (int i = 0; i < 250; i++)
			pending_poses.push_back(random_pose(epsilon));
		wait_idle();

		foreach (settings[k]) begin
			write_epsilon(settings[k]);
			if (k == 0) begin
				// A zero epsilon must still refuse an exactly zero parent scale.
				p = plain_pose(); p.psx = 32'h0; pending_poses.push_back(p);
				p = plain_pose(); p.psy = 32'h0; p.psx = 32'h1; pending_poses.push_back(p);
			end else begin
				p = plain_pose(); p.psx = 32'(settings[k]) - 32'd1;
				pending_poses.push_back(p);
				p = plain_pose(); p.psx = -32'(settings[k]); p.psy = 32'(settings[k]);
				pending_poses.push_back(p);
			end
			for (int i = 0; i < 255; i++)
				pending_poses.push_back(random_pose(epsilon));
			wait_idle();
		end

		$display("%0d poses checked under %0d epsilon settings, one long output stall",
			received, 6);
		$display("modes computed/keep/world: %0d/%0d/%0d, saturated results: %0d",
			mode_seen[0], mode_seen[1], mode_seen[2], n_sat);
		if (errors == 0 && expected_poses.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: world_to_local_transform_2d.f
src/w2l_pkg.sv
src/w2l_queue.sv
src/w2l_front.sv
src/w2l_cordic.sv
src/w2l_div.sv
src/w2l_back.sv
src/world_to_local_transform_2d.sv
sim/world_to_local_transform_2d_tb.sv
